[hw/rtl/ssp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo slew positioner package
// Shared widths, command and register codes, channel types and the window
// clamp used by the positioner's channels.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int NUM_CHANNELS = 3;
    // Only three channels have ports and registers; more are never built.
    localparam int CH_COUNT     = (NUM_CHANNELS < 3) ? NUM_CHANNELS : 3;
    localparam int OUT_CHANNELS = 3;

    localparam int COUNT_W      = 16;
    localparam int CHAN_W       = 2;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET  = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAD_MIN  = 3'd0,
        REG_HEAD_MAX  = 3'd1,
        REG_LEFT_MIN  = 3'd2,
        REG_LEFT_MAX  = 3'd3,
        REG_RIGHT_MIN = 3'd4,
        REG_RIGHT_MAX = 3'd5,
        REG_STEP_SIZE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        count_t win_min;
        count_t win_max;
    } window_t;

    // Per-channel operation strobes, each already qualified by the commit.
    typedef struct packed {
        logic set_en;
        logic move_en;
        logic tick_en;
    } chan_op_t;

    // The upper bound is tested first, so an inverted window clamps values
    // above it to the upper bound and all others to the lower bound.
    function automatic count_t clamp_count(input count_t v, input window_t w);
        count_t r;
        if (v > w.win_max)
        begin
            r = w.win_max;
        end
        else if (v < w.win_min)
        begin
            r = w.win_min;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hw/rtl/servo_slew_positioner_core.sv]
`timescale 1ns / 1ps
// An accepted input beat is loaded into the input register and moves on to the
// result register when it commits; a stalled output holds it in the input register.
// Throughput: one item per cycle while the output is not stalled; the channel state
// updates in the same cycle the result is registered, so the next item sees it at once.
// Reset: positions, targets and ramp flags clear to zero, windows open fully
// and the step size returns to one; both pipeline stages come up empty.
// ----------------------------------------------------------------------------
// Servo slew positioner core
// Three-channel servo pulse-width positioner with windowed set, smooth move
// arming and slew-limited ticks; one result beat per command beat.
// ----------------------------------------------------------------------------
module servo_slew_positioner_core
    import ssp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CMD_W-1:0]        cmd,
    input  logic [CHAN_W-1:0]       channel,
    input  logic [COUNT_W-1:0]      start_count,
    input  logic [COUNT_W-1:0]      target_count,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [COUNT_W-1:0]      head_position,
    output logic [COUNT_W-1:0]      left_position,
    output logic [COUNT_W-1:0]      right_position,
    output logic [OUT_CHANNELS-1:0] moving_mask,
    output logic                    rejected
);

    window_t                 windows [CH_COUNT];
    count_t                  step_size;

    logic                    item_valid_reg;
    logic                    item_valid_next;
    logic [CMD_W-1:0]        cmd_reg;
    logic [CHAN_W-1:0]       chan_reg;
    count_t                  start_reg;
    count_t                  target_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    count_t                  res_pos_reg [OUT_CHANNELS];
    logic [OUT_CHANNELS-1:0] res_mask_reg;
    logic                    res_rej_reg;

    logic                    advance;
    logic                    commit;
    logic                    in_fire;
    cmd_t                    cmd_code;
    logic                    is_set;
    logic                    is_move;
    logic                    is_tick;
    count_t                  ch_pos [OUT_CHANNELS];
    logic [OUT_CHANNELS-1:0] ch_active;
    logic [OUT_CHANNELS-1:0] ch_reject;
    logic [OUT_CHANNELS-1:0] ch_touch;

    ssp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .windows   (windows),
        .step_size (step_size)
    );

    // The result register takes a new beat when empty or being drained.
    assign advance  = !out_valid_reg || !out_stall;
    assign commit   = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    assign item_valid_next = in_fire || (item_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= cmd;
            chan_reg   <= channel;
            start_reg  <= start_count;
            target_reg <= target_count;
        end
    end

    always_comb
    begin
        cmd_code = cmd_t'(cmd_reg);
        is_set   = 1'b0;
        is_move  = 1'b0;
        is_tick  = 1'b0;
        case (cmd_code)
            CMD_SET:  is_set  = 1'b1;
            CMD_MOVE: is_move = 1'b1;
            CMD_TICK: is_tick = 1'b1;
            default:  ;
        endcase
    end

    for (genvar c = 0; c < OUT_CHANNELS; c++)
    begin : g_chan
        if (c < CH_COUNT)
        begin : g_live
            chan_op_t ops;
            logic     sel;

            assign sel         = (chan_reg == CHAN_W'(c));
            assign ops.set_en  = commit && is_set && sel;
            assign ops.move_en = commit && is_move && sel;
            assign ops.tick_en = commit && is_tick;
            assign ch_touch[c] = ops.set_en || ops.move_en;

            ssp_channel u_channel (
                .clk          (clk),
                .rst_n        (rst_n),
                .ops          (ops),
                .start_count  (start_reg),
                .target_count (target_reg),
                .window       (windows[c]),
                .step_size    (step_size),
                .pos_next     (ch_pos[c]),
                .active_next  (ch_active[c]),
                .reject       (ch_reject[c])
            );
        end
        else
        begin : g_absent
            assign ch_pos[c]    = '0;
            assign ch_active[c] = 1'b0;
            assign ch_reject[c] = 1'b0;
            assign ch_touch[c]  = 1'b0;
        end
    end

    assign out_valid_next = commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            for (int c = 0; c < OUT_CHANNELS; c++)
            begin
                res_pos_reg[c] <= ch_pos[c];
            end
            res_mask_reg <= ch_active;
            res_rej_reg  <= |ch_reject;
        end
    end

    assign out_valid      = out_valid_reg;
    assign head_position  = res_pos_reg[0];
    assign left_position  = res_pos_reg[1];
    assign right_position = res_pos_reg[2];
    assign moving_mask    = res_mask_reg;
    assign rejected       = res_rej_reg;

    // Every committed item lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed beat did not reach the result register");

    // A set or a move addresses one channel at most.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ch_touch))
        else $error("more than one channel addressed by one command");

    // Only a smooth move can be refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !is_move) |=> !res_rej_reg)
        else $error("rejection flagged on a command other than a move");

endmodule

[hw/rtl/ssp_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo slew positioner configuration registers
// Holds the per-channel pulse windows and the ramp step size, written
// through a plain indexed write port.
// ----------------------------------------------------------------------------
module ssp_cfg_regs
    import ssp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output window_t               windows [CH_COUNT],
    output count_t                step_size
);

    count_t step_reg;
    count_t step_next;

    for (genvar c = 0; c < CH_COUNT; c++)
    begin : g_win
        // Each channel owns a min/max pair of consecutive register indexes.
        localparam logic [CFG_IDX_W-1:0] MIN_IDX =
            CFG_IDX_W'(int'(REG_HEAD_MIN) + 2 * c);
        localparam logic [CFG_IDX_W-1:0] MAX_IDX =
            CFG_IDX_W'(int'(REG_HEAD_MAX) + 2 * c);

        window_t win_reg;
        window_t win_next;

        always_comb
        begin
            win_next = win_reg;
            if (cfg_we && (cfg_index == MIN_IDX))
            begin
                win_next.win_min = COUNT_W'(cfg_data);
            end
            if (cfg_we && (cfg_index == MAX_IDX))
            begin
                win_next.win_max = COUNT_W'(cfg_data);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                win_reg.win_min <= '0;
                win_reg.win_max <= '1;
            end
            else
            begin
                win_reg <= win_next;
            end
        end

        assign windows[c] = win_reg;
    end

    always_comb
    begin
        step_next = step_reg;
        if (cfg_we && (cfg_index == REG_STEP_SIZE))
        begin
            step_next = COUNT_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= COUNT_W'(1);
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign step_size = step_reg;

endmodule

[hw/rtl/ssp_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo slew positioner channel
// Position, target and ramp flag of one servo, with the immediate set,
// smooth move arming and the per-tick slew step toward the target.
// ----------------------------------------------------------------------------
module ssp_channel
    import ssp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  chan_op_t ops,
    input  count_t   start_count,
    input  count_t   target_count,
    input  window_t  window,
    input  count_t   step_size,
    output count_t   pos_next,
    output logic     active_next,
    output logic     reject
);

    count_t           pos_reg;
    count_t           tgt_reg;
    logic             active_reg;
    count_t           tgt_next;
    count_t           step_eff;
    count_t           move_end;
    logic             start_outside;
    logic [COUNT_W:0] sum_up;
    count_t           diff_down;
    count_t           tick_pos;

    assign step_eff      = (step_size == '0) ? COUNT_W'(1) : step_size;
    assign move_end      = clamp_count(target_count, window);
    assign start_outside = (start_count > window.win_max) ||
                           (start_count < window.win_min);
    assign reject        = ops.move_en && start_outside;

    assign sum_up    = {1'b0, pos_reg} + {1'b0, step_eff};
    assign diff_down = pos_reg - tgt_reg;

    // One slew step, saturating at the target from either side.
    always_comb
    begin
        if (pos_reg < tgt_reg)
        begin
            tick_pos = (sum_up > {1'b0, tgt_reg}) ? tgt_reg : sum_up[COUNT_W-1:0];
        end
        else if (pos_reg > tgt_reg)
        begin
            tick_pos = (diff_down > step_eff) ? (pos_reg - step_eff) : tgt_reg;
        end
        else
        begin
            tick_pos = pos_reg;
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        tgt_next    = tgt_reg;
        active_next = active_reg;
        if (ops.set_en)
        begin
            pos_next    = move_end;
            active_next = 1'b0;
        end
        else if (ops.move_en)
        begin
            // A move onto the start position leaves any running ramp alone.
            if (!start_outside && (move_end != start_count))
            begin
                pos_next    = start_count;
                tgt_next    = move_end;
                active_next = 1'b1;
            end
        end
        else if (ops.tick_en && active_reg)
        begin
            pos_next = tick_pos;
            if (tick_pos == tgt_reg)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            tgt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            tgt_reg    <= tgt_next;
            active_reg <= active_next;
        end
    end

    // A running ramp never sits on its own target.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(active_reg && (pos_reg == tgt_reg)))
        else $error("ramp active with position already at target");

    // A tick leaves an idle channel where it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ops.tick_en && !active_reg) |=> (pos_reg == $past(pos_reg)))
        else $error("idle channel moved on a tick");

endmodule
